// ===== hw/rtl/apvf_pkg.sv =====
// shared constants for the arm position and velocity filter
// field widths, register indexes, reset values and reciprocal for the wheel means
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package apvf_pkg;

  localparam int WHEEL_COUNT = 6;

  // field widths
  localparam int WHEEL_W = 3;
  localparam int MV_W    = 13;
  localparam int POS_W   = 10;
  localparam int VEL_W   = 16;
  localparam int GAIN_W  = 15;
  localparam int COEF_W  = 4;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_SPAN_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_STROKE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_COEF   = 3'd4;

  localparam logic [MV_W-1:0]   RST_SPAN_LOW    = 13'd500;
  localparam logic [MV_W-1:0]   RST_SPAN_HIGH   = 13'd4500;
  localparam logic [POS_W-1:0]  RST_FULL_STROKE = 10'd485;
  localparam logic [GAIN_W-1:0] RST_VEL_GAIN    = 15'd29789;
  localparam logic [COEF_W-1:0] RST_VEL_COEF    = 4'd5;

  // per-wheel store indexing
  localparam int WIDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

  // running sums, kept exact
  localparam int PSUM_W = $clog2(WHEEL_COUNT * 1023 + 1);
  localparam int VMAG_W = $clog2(WHEEL_COUNT * 32768 + 1);
  localparam int VSUM_W = VMAG_W + 1;

  // division by the wheel count as multiply by a rounded-up reciprocal
  localparam int MEAN_SHIFT  = VMAG_W + $clog2(WHEEL_COUNT);
  localparam int MEAN_MULT_W = MEAN_SHIFT + 1;
  localparam logic [MEAN_MULT_W-1:0] MEAN_MULT =
    MEAN_MULT_W'(((64'd1 << MEAN_SHIFT) + WHEEL_COUNT - 1) / WHEEL_COUNT);

  // velocity filter arithmetic
  localparam int DIFF_W = POS_W + 1;
  localparam int ACC_W  = 18;

  // shared multiplier operands
  localparam int MUL_A_W = (VMAG_W + 1 > ACC_W + 1) ? VMAG_W + 1 : ACC_W + 1;
  localparam int MUL_B_W = (MEAN_MULT_W > 16) ? MEAN_MULT_W : 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

  // stroke scaling divider
  localparam int DIVIDEND_W = MV_W + POS_W;
  localparam int DIVISOR_W  = MV_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

endpackage

`default_nettype wire

// ===== hw/rtl/apvf_div.sv =====
// restoring divider for the stroke scaling, one quotient bit per cycle
// depends on apvf_pkg for the operand widths
`timescale 1ns / 1ps
`default_nettype none

module apvf_div import apvf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    trial = {rem, quo[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ===== hw/rtl/arm_position_velocity_filter.sv =====
// arm position and velocity filter: one sensor sample in, one result beat out
// an input beat passes the scale multiply, the 23-step divider, the coefficient and
// gain multiplies, the update, the means and the output load; a zero stroke skips the
// divider and a wheel out of range goes straight to the means; one item at a time, the
// next beat is taken in the cycle after the result is loaded; a held output delays the load
// a single multiplier is shared by the scaling, the filter and the wheel means
// synchronous reset restores the default span, stroke, gain and coefficient and clears all stores
`timescale 1ns / 1ps
`default_nettype none

module arm_position_velocity_filter import apvf_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // wheel_index, sample_mv
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // wheel_echo, position_mm, velocity,
                                                     // mean_height_mm, mean_velocity
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SMUL   = 4'd1;
  localparam logic [3:0] S_DSTART = 4'd2;
  localparam logic [3:0] S_DWAIT  = 4'd3;
  localparam logic [3:0] S_DMUL   = 4'd4;
  localparam logic [3:0] S_GMUL   = 4'd5;
  localparam logic [3:0] S_SAT    = 4'd6;
  localparam logic [3:0] S_MP     = 4'd7;
  localparam logic [3:0] S_MV     = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  localparam logic signed [PROD_W-1:0] VEL_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] VEL_MIN = PROD_W'(-32768);

  // configuration
  logic [MV_W-1:0]   span_low;
  logic [MV_W-1:0]   span_high;
  logic [POS_W-1:0]  full_stroke;
  logic [GAIN_W-1:0] vel_gain;
  logic [COEF_W-1:0] vel_coef;

  // state
  logic [3:0]              state;
  logic [WHEEL_W-1:0]      wheel;
  logic [MV_W-1:0]         mv;
  logic [POS_W-1:0]        p_old;
  logic signed [VEL_W-1:0] v_old;
  logic [POS_W-1:0]        pos;
  logic signed [VEL_W-1:0] vel;
  logic [POS_W-1:0]        mean_h;
  logic signed [PROD_W-1:0] mul_p;
  logic [POS_W-1:0]        pos_store [WHEEL_COUNT];
  logic signed [VEL_W-1:0] vel_store [WHEEL_COUNT];
  logic [PSUM_W-1:0]       psum;
  logic signed [VSUM_W-1:0] vsum;
  logic [OUT_TDATA_W-1:0]  out_data;
  logic                    out_valid;

  // input fields
  logic [WHEEL_W-1:0] in_wheel;
  logic [MV_W-1:0]    in_mv;
  logic               in_ok;
  logic [WIDX_W-1:0]  in_idx;
  logic [WIDX_W-1:0]  idx;

  assign in_wheel = s_axis_tdata[WHEEL_W-1:0];
  assign in_mv    = s_axis_tdata[WHEEL_W +: MV_W];
  assign in_ok    = (int'(in_wheel) < WHEEL_COUNT);
  assign in_idx   = WIDX_W'(in_wheel);
  assign idx      = WIDX_W'(wheel);

  // datapath helpers
  logic [MV_W-1:0]          num;
  logic [MV_W-1:0]          span;
  logic                     pos_zero;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] vq;
  logic signed [VEL_W-1:0]  vel_new;
  logic [VMAG_W-1:0]        vmag;
  logic [VEL_W:0]           mv_mag;
  logic [VEL_W-1:0]         mean_v;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic                     load_out;

  // divider
  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_q;

  always_comb begin
    num      = mv - span_low;
    span     = span_high - span_low;
    pos_zero = (span_high <= span_low) || (mv <= span_low);
    diff     = signed'(DIFF_W'(pos)) - signed'(DIFF_W'(p_old));
    acc      = ACC_W'(v_old) + ACC_W'(mul_p);
    // truncate toward zero before the Q0.15 shift
    rnd      = mul_p;
    if (mul_p[PROD_W-1]) begin
      rnd = mul_p + PROD_W'(32767);
    end
    vq = rnd >>> 15;
    priority if (vq > VEL_MAX) begin
      vel_new = 16'sh7fff;
    end else if (vq < VEL_MIN) begin
      vel_new = -16'sh8000;
    end else begin
      vel_new = vq[VEL_W-1:0];
    end
    vmag   = vsum[VSUM_W-1] ? VMAG_W'(-vsum) : VMAG_W'(vsum);
    mv_mag = mul_p[MEAN_SHIFT +: VEL_W+1];
    mean_v = vsum[VSUM_W-1] ? VEL_W'(-mv_mag) : VEL_W'(mv_mag);
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      S_SMUL: begin
        mul_a = MUL_A_W'(num);
        mul_b = MUL_B_W'(full_stroke);
      end
      S_DMUL: begin
        mul_a = MUL_A_W'(diff);
        mul_b = MUL_B_W'(vel_coef);
      end
      S_GMUL: begin
        mul_a = MUL_A_W'(acc);
        mul_b = MUL_B_W'(vel_gain);
      end
      S_MP: begin
        mul_a = MUL_A_W'(psum);
        mul_b = MUL_B_W'(MEAN_MULT);
      end
      S_MV: begin
        mul_a = MUL_A_W'(vmag);
        mul_b = MUL_B_W'(MEAN_MULT);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // the velocity mean product is held while the result waits for the output register
  always_ff @(posedge clk) begin
    if (state != S_FIN) begin
      mul_p <= mul_a * signed'({1'b0, mul_b});
    end
  end

  assign div_start = (state == S_DSTART);
  assign load_out  = (state == S_FIN) && (!out_valid || m_axis_tready);

  apvf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p[DIVIDEND_W-1:0]),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_q)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      span_low    <= RST_SPAN_LOW;
      span_high   <= RST_SPAN_HIGH;
      full_stroke <= RST_FULL_STROKE;
      vel_gain    <= RST_VEL_GAIN;
      vel_coef    <= RST_VEL_COEF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SPAN_LOW:    span_low    <= cfg_data[MV_W-1:0];
        REG_SPAN_HIGH:   span_high   <= cfg_data[MV_W-1:0];
        REG_FULL_STROKE: full_stroke <= cfg_data[POS_W-1:0];
        REG_VEL_GAIN:    vel_gain    <= cfg_data[GAIN_W-1:0];
        REG_VEL_COEF:    vel_coef    <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and per-wheel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      psum  <= '0;
      vsum  <= '0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        pos_store[i] <= '0;
        vel_store[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            wheel <= in_wheel;
            mv    <= in_mv;
            pos   <= '0;
            vel   <= '0;
            if (in_ok) begin
              p_old <= pos_store[in_idx];
              v_old <= vel_store[in_idx];
              state <= S_SMUL;
            end else begin
              state <= S_MP;
            end
          end
        end
        S_SMUL: begin
          state <= pos_zero ? S_DMUL : S_DSTART;
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            if (div_q > DIVIDEND_W'(full_stroke)) begin
              pos <= full_stroke;
            end else begin
              pos <= div_q[POS_W-1:0];
            end
            state <= S_DMUL;
          end
        end
        S_DMUL: begin
          state <= S_GMUL;
        end
        S_GMUL: begin
          state <= S_SAT;
        end
        S_SAT: begin
          vel            <= vel_new;
          pos_store[idx] <= pos;
          vel_store[idx] <= vel_new;
          psum           <= psum - PSUM_W'(p_old) + PSUM_W'(pos);
          vsum           <= vsum - VSUM_W'(v_old) + VSUM_W'(vel_new);
          state          <= S_MP;
        end
        S_MP: begin
          state <= S_MV;
        end
        S_MV: begin
          mean_h <= mul_p[MEAN_SHIFT +: POS_W];
          state  <= S_FIN;
        end
        S_FIN: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {1'b0, mean_v, mean_h, vel, pos, wheel};
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // checks

  // the sums only move in the update step
  assert property (@(posedge clk) disable iff (rst)
    (state != S_SAT) |=> ($stable(psum) && $stable(vsum)))
    else $error("running sums changed outside the update step");

  // the divider only reports while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DWAIT))
    else $error("divider finished outside the wait step");

  // a result beat never reports a stroke beyond the configured full stroke
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[WHEEL_W +: POS_W] <= full_stroke))
    else $error("position beyond full stroke");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the arm position and velocity filter
// drives sensor beats and register writes, predicts every result beat in a scoreboard class
// depends on apvf_pkg and arm_position_velocity_filter
`timescale 1ns / 1ps

module testbench;
  import apvf_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 210;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 40;
  localparam int MAX_REPORTS  = 40;
  localparam int WATCHDOG_NS  = 5_000_000;

  localparam int MV_TOP     = 5000;
  localparam int STROKE_TOP = 1000;
  localparam int GAIN_TOP   = 32767;
  localparam int COEF_TOP   = 15;
  localparam int WHEEL_TOP  = (1 << WHEEL_W) - 1;

  localparam longint Q15_ONE = 32768;
  localparam longint VEL_MAX = 32767;
  localparam longint VEL_MIN = -32768;

  // result beat layout, lowest field first
  localparam int OFF_POS   = WHEEL_W;
  localparam int OFF_VEL   = OFF_POS + POS_W;
  localparam int OFF_MHGT  = OFF_VEL + VEL_W;
  localparam int OFF_MVEL  = OFF_MHGT + POS_W;

  typedef struct {
    logic [WHEEL_W-1:0]      wheel;
    logic [POS_W-1:0]        position;
    logic signed [VEL_W-1:0] velocity;
    logic [POS_W-1:0]        mean_height;
    logic signed [VEL_W-1:0] mean_velocity;
  } wheel_result_t;

  class filter_scoreboard;
    int unsigned   span_low, span_high, full_stroke, gain, coef;
    int unsigned   stroke_mm [WHEEL_COUNT];
    int            wheel_velocity [WHEEL_COUNT];
    int unsigned   height_total;
    int            velocity_total;
    wheel_result_t awaited [$];
    int            failures, checked, reported;

    function new();
      span_low    = 32'(RST_SPAN_LOW);
      span_high   = 32'(RST_SPAN_HIGH);
      full_stroke = 32'(RST_FULL_STROKE);
      gain        = 32'(RST_VEL_GAIN);
      coef        = 32'(RST_VEL_COEF);
      foreach (stroke_mm[i]) begin
        stroke_mm[i]      = 0;
        wheel_velocity[i] = 0;
      end
      height_total   = 0;
      velocity_total = 0;
      failures = 0;
      checked  = 0;
      reported = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SPAN_LOW:    span_low    = 32'(value[MV_W-1:0]);
        REG_SPAN_HIGH:   span_high   = 32'(value[MV_W-1:0]);
        REG_FULL_STROKE: full_stroke = 32'(value[POS_W-1:0]);
        REG_VEL_GAIN:    gain        = 32'(value[GAIN_W-1:0]);
        REG_VEL_COEF:    coef        = 32'(value[COEF_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_sample(logic [WHEEL_W-1:0] wheel, logic [MV_W-1:0] mv);
      wheel_result_t r;
      int unsigned   pos, p_old;
      int            v_old;
      longint        acc, v;
      r.wheel    = wheel;
      r.position = '0;
      r.velocity = '0;
      if (wheel < WHEEL_COUNT) begin
        p_old = stroke_mm[wheel];
        v_old = wheel_velocity[wheel];
        pos   = 0;
        // empty or inverted span, or a reading at the low end, gives zero stroke
        if (span_high > span_low && mv > span_low) begin
          pos = ((mv - span_low) * full_stroke) / (span_high - span_low);
          if (pos > full_stroke) pos = full_stroke;
        end
        acc = longint'(v_old) + longint'(coef) * (longint'(pos) - longint'(p_old));
        v   = (acc * longint'(gain)) / Q15_ONE;
        if (v > VEL_MAX) v = VEL_MAX;
        if (v < VEL_MIN) v = VEL_MIN;
        height_total   = height_total - p_old + pos;
        velocity_total = velocity_total - v_old + int'(v);
        stroke_mm[wheel]      = pos;
        wheel_velocity[wheel] = int'(v);
        r.position = POS_W'(pos);
        r.velocity = VEL_W'(v);
      end
      r.mean_height   = POS_W'(height_total / WHEEL_COUNT);
      r.mean_velocity = VEL_W'(velocity_total / WHEEL_COUNT);
      awaited.push_back(r);
    endfunction

    function void compare_field(string label, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        failures++;
        if (reported < MAX_REPORTS)
          $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
        reported++;
      end
    endfunction

    function void check_beat(logic [OUT_TDATA_W-1:0] beat);
      wheel_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        failures++;
        if (reported < MAX_REPORTS)
          $display("%0t: result beat with nothing expected, expected none actual %h",
                   $time, beat);
        reported++;
        return;
      end
      want = awaited.pop_front();
      compare_field("wheel_echo", 32'(want.wheel), 32'(beat[WHEEL_W-1:0]));
      compare_field("position_mm", 32'(want.position), 32'(beat[OFF_POS +: POS_W]));
      compare_field("velocity", 32'(want.velocity), 32'($signed(beat[OFF_VEL +: VEL_W])));
      compare_field("mean_height_mm", 32'(want.mean_height), 32'(beat[OFF_MHGT +: POS_W]));
      compare_field("mean_velocity", 32'(want.mean_velocity),
                    32'($signed(beat[OFF_MVEL +: VEL_W])));
    endfunction
  endclass

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // wheel_index, sample_mv
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // wheel_echo, position_mm, velocity,
                                               // mean_height_mm, mean_velocity
  logic                   cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;

  filter_scoreboard sb = new;
  int unsigned      beats_sent     = 0;
  bit               sender_idles   = 1'b1;
  bit               receiver_idles = 1'b1;
  bit               hold_output    = 1'b0;

  arm_position_velocity_filter DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // result beats are checked before the input beat of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_sample(s_axis_tdata[WHEEL_W-1:0], s_axis_tdata[WHEEL_W +: MV_W]);
      if (cfg_wr_en) sb.write_register(cfg_index, cfg_data);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned lo, input int unsigned hi,
                              input int unsigned stroke, input int unsigned vgain,
                              input int unsigned vcoef);
    write_reg(REG_SPAN_LOW, CFG_DATA_W'(lo));
    write_reg(REG_SPAN_HIGH, CFG_DATA_W'(hi));
    write_reg(REG_FULL_STROKE, CFG_DATA_W'(stroke));
    write_reg(REG_VEL_GAIN, CFG_DATA_W'(vgain));
    write_reg(REG_VEL_COEF, CFG_DATA_W'(vcoef));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_sample(input int unsigned wheel, input int unsigned mv);
    int unsigned gap;
    gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {MV_W'(mv), WHEEL_W'(wheel)};
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
  endtask

  // every result in, then a margin for the block to fall idle
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (sb.checked < beats_sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : receiver
    int unsigned gap;
    forever begin
      if (hold_output) begin
        // long hold so the block fills and back-pressures its input
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output = 1'b0;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 3);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned phase, n, wheel, mv, lo, hi;
    int          idx;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: span edges, saturation, widest code and unused wheel slots
    send_sample(0, 0);
    send_sample(1, 500);
    send_sample(2, 501);
    send_sample(3, 4500);
    send_sample(4, 4499);
    send_sample(5, 5000);
    send_sample(0, 8191);
    send_sample(6, 2000);
    send_sample(7, 8191);
    send_sample(1, 2500);
    send_sample(0, 0);
    send_sample(2, 5000);
    settle_block();

    // one millivolt of span, widest stroke, full gain and coefficient: hardest swings
    program_regs(0, 1, (1 << POS_W) - 1, GAIN_TOP, COEF_TOP);
    send_sample(0, 1);
    send_sample(0, 0);
    send_sample(0, 8191);
    send_sample(1, 1);
    send_sample(2, 1);
    send_sample(3, 1);
    send_sample(4, 1);
    send_sample(5, 1);
    send_sample(5, 0);
    send_sample(7, 0);
    settle_block();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          // writes past the register list must leave everything alone
          for (idx = REG_VEL_COEF + 1; idx < 2 ** CFG_IDX_W; idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
          program_regs(RST_SPAN_LOW, RST_SPAN_HIGH, RST_FULL_STROKE, RST_VEL_GAIN,
                       RST_VEL_COEF);
        end
        1: program_regs(0, MV_TOP, STROKE_TOP, GAIN_TOP, COEF_TOP);
        2: program_regs(MV_TOP, 0, $urandom_range(1, STROKE_TOP), $urandom_range(0, GAIN_TOP),
                        $urandom_range(0, COEF_TOP));
        3: program_regs(2500, 2500, $urandom_range(1, STROKE_TOP),
                        $urandom_range(0, GAIN_TOP), $urandom_range(0, COEF_TOP));
        // over-wide values keep only their low bits: 100, 8191, 1, 0, 0
        4: program_regs('h6064, 'h7fff, 'h7c01, 0, 'h7ff0);
        default: begin
          lo = $urandom_range(0, MV_TOP - 1);
          hi = $urandom_range(lo + 1, MV_TOP);
          program_regs(lo, hi, $urandom_range(1, STROKE_TOP), $urandom_range(0, GAIN_TOP),
                       $urandom_range(0, COEF_TOP));
        end
      endcase
      if (phase == 1) hold_output = 1'b1;
      if (phase == PHASES - 1) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end
      for (n = 0; n < PHASE_BEATS; n++) begin
        wheel = ($urandom_range(0, 9) == 0) ? $urandom_range(WHEEL_COUNT, WHEEL_TOP)
                                            : $urandom_range(0, WHEEL_COUNT - 1);
        case ($urandom_range(0, 7))
          0: mv = $urandom_range(0, (1 << MV_W) - 1);
          1: mv = sb.span_low + $urandom_range(0, 2) - 1;
          2: mv = sb.span_high + $urandom_range(0, 2) - 1;
          default: mv = $urandom_range(0, MV_TOP);
        endcase
        send_sample(wheel, mv);
      end
      settle_block();
    end

    $display("%0d sensor beats over %0d register settings, %0d result beats checked",
             beats_sent, PHASES + 2, sb.checked);
    $display("covered span edges, empty and inverted spans, masked writes, unused wheels");
    if (sb.failures == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/apvf_pkg.sv
hw/rtl/apvf_div.sv
hw/rtl/arm_position_velocity_filter.sv
bench/testbench.sv
